// ----- rtl/core/crc_fpe_pkg.sv -----
// ----------------------------------------------------------------------------
// crc_fpe_pkg
// shared types, constants and the crc byte update for the framed emitter
// ----------------------------------------------------------------------------
package crc_fpe_pkg;

	localparam logic [7:0]  MAX_PAYLOAD  = 8'd240;
	localparam logic [7:0]  MIN_PAYLOAD  = 8'd2;
	localparam logic [7:0]  MAGIC_BYTE   = 8'hFE;
	localparam logic [15:0] CRC_POLY     = 16'h1021;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam int          CRC_TOP_BIT  = 15;
	localparam int          HEADER_BYTES = 14;
	localparam int          STEP_W       = 4;

	// last step of a frame's first item: header then the payload byte
	localparam logic [STEP_W-1:0] STEP_FIRST_LAST = STEP_W'(HEADER_BYTES);
	localparam logic [STEP_W-1:0] STEP_PAYLOAD    = '0;
	localparam logic [STEP_W-1:0] STEP_CRC_LO     = STEP_W'(1);
	localparam logic [STEP_W-1:0] STEP_CRC_HI     = STEP_W'(2);

	localparam logic [1:0] REG_SESSION_ID   = 2'd0;
	localparam logic [1:0] REG_SESSION_OPEN = 2'd1;

	typedef struct packed {
		logic [7:0] frame_len;
		logic [7:0] payload_byte;
	} item_t;

	typedef struct packed {
		logic [63:0] session_id;
		logic        session_open;
		logic        seq_clr;
	} cfg_t;

	typedef struct packed {
		logic [15:0] sequence_now;
		logic        rejected;
		logic        frame_done;
		logic        run_last;
		logic [7:0]  out_byte;
	} res_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int j = 0; j < 8; j++) begin
			if (c[CRC_TOP_BIT]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	// header byte at position k of the frame
	function automatic logic [7:0] header_byte(input logic [STEP_W-1:0] k,
			input logic [63:0] sid, input logic [15:0] seq, input logic [7:0] len);
		logic [7:0] b;
		case (k)
			4'd0:    b = MAGIC_BYTE;
			4'd1:    b = MAGIC_BYTE;
			4'd2:    b = sid[7:0];
			4'd3:    b = sid[15:8];
			4'd4:    b = sid[23:16];
			4'd5:    b = sid[31:24];
			4'd6:    b = sid[39:32];
			4'd7:    b = sid[47:40];
			4'd8:    b = sid[55:48];
			4'd9:    b = sid[63:56];
			4'd10:   b = seq[7:0];
			4'd11:   b = seq[15:8];
			4'd12:   b = len;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ----- rtl/core/crc_framed_payload_emitter.sv -----
// ----------------------------------------------------------------------------
// crc_framed_payload_emitter
// frames payload bytes with a session header and a crc-16/ccitt-false trailer
// ----------------------------------------------------------------------------
// Each payload byte in gives one or more framed bytes out, one per cycle
// through a single output register unless the output stalls. A rejected
// item or a mid-frame byte gives one byte, so such items stream at one per
// cycle; the first byte of a frame gives 14 header bytes plus the payload
// byte and the closing byte gives the payload plus two crc bytes. Input is
// held off while the output register works through an item's bytes.
module crc_framed_payload_emitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // payload_byte[7:0], frame_len[15:8]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // out_byte[7:0], sequence_now[23:8]
	output logic        m_axis_tlast,
	output logic [1:0]  m_axis_tuser,   // frame_done[0], rejected[1]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import crc_fpe_pkg::*;

	logic [63:0] session_id_q;
	logic        session_open_q;
	logic        cfg_wr;
	cfg_t        cfg;
	item_t       item_in;
	item_t       item_s1;
	logic        valid_s1;
	logic        item_done;
	res_t        res;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_id_q   <= '0;
			session_open_q <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_SESSION_ID:   session_id_q   <= cfg_data;
				REG_SESSION_OPEN: session_open_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.session_id   = session_id_q;
	assign cfg.session_open = session_open_q;
	assign cfg.seq_clr      = cfg_wr && (cfg_index == REG_SESSION_ID);

	assign item_in.payload_byte = s_axis_tdata[7:0];
	assign item_in.frame_len    = s_axis_tdata[15:8];

	crc_fpe_in u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.item_in       (item_in),
		.item_done     (item_done),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1)
	);

	crc_fpe_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.item_done (item_done),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {res.sequence_now, res.out_byte};
	assign m_axis_tlast = res.run_last;
	assign m_axis_tuser = {res.rejected, res.frame_done};

endmodule

// ----- rtl/core/crc_fpe_in.sv -----
// ----------------------------------------------------------------------------
// crc_fpe_in
// input register stage: holds one accepted item until its results are out
// ----------------------------------------------------------------------------
module crc_fpe_in (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  crc_fpe_pkg::item_t  item_in,
	input  logic                item_done,
	output logic                valid_s1,
	output crc_fpe_pkg::item_t  item_s1
);
	import crc_fpe_pkg::*;

	logic vld_s1;

	assign s_axis_tready = !vld_s1 || item_done;
	assign valid_s1      = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= item_in;
		end
	end

endmodule

// ----- rtl/core/crc_fpe_emit.sv -----
// ----------------------------------------------------------------------------
// crc_fpe_emit
// frame sequencer: one framed byte per cycle, unless the output stalls, into the result register
// ----------------------------------------------------------------------------
module crc_fpe_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  crc_fpe_pkg::cfg_t   cfg,
	input  logic                valid_s1,
	input  crc_fpe_pkg::item_t  item_s1,
	output logic                item_done,
	output logic                out_valid,
	input  logic                out_ready,
	output crc_fpe_pkg::res_t   res
);
	import crc_fpe_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic [15:0]       crc_q;
	logic [15:0]       seq_q;
	logic [7:0]        left_q;
	logic              inside_q;
	logic              out_valid_q;
	res_t              res_q;

	logic        fire;
	logic        rej;
	logic        is_last;
	logic        feed;
	logic        frame_end;
	logic [7:0]  byte_nx;
	logic [15:0] crc_base;
	res_t        res_nx;

	assign fire      = valid_s1 && (!out_valid_q || out_ready);
	assign item_done = fire && is_last;
	assign out_valid = out_valid_q;
	assign res       = res_q;

	assign rej = !cfg.session_open ||
		(!inside_q && ((item_s1.frame_len < MIN_PAYLOAD) || (item_s1.frame_len > MAX_PAYLOAD)));
	assign crc_base = (!inside_q && step_q == '0) ? CRC_INIT : crc_q;

	always_comb begin
		byte_nx   = 8'h00;
		is_last   = 1'b0;
		feed      = 1'b0;
		frame_end = 1'b0;
		res_nx    = '0;
		if (rej) begin
			is_last = 1'b1;
		end else if (!inside_q) begin
			feed = 1'b1;
			if (step_q == STEP_FIRST_LAST) begin
				byte_nx = item_s1.payload_byte;
				is_last = 1'b1;
			end else begin
				byte_nx = header_byte(step_q, cfg.session_id, seq_q, item_s1.frame_len);
			end
		end else begin
			case (step_q)
				STEP_PAYLOAD: begin
					byte_nx = item_s1.payload_byte;
					feed    = 1'b1;
					is_last = (left_q > 8'd1);
				end
				STEP_CRC_LO: begin
					byte_nx = crc_q[7:0];
				end
				STEP_CRC_HI: begin
					byte_nx   = crc_q[15:8];
					is_last   = 1'b1;
					frame_end = 1'b1;
				end
				default: begin
					byte_nx = 8'h00;
				end
			endcase
		end
		res_nx.out_byte     = byte_nx;
		res_nx.run_last     = is_last;
		res_nx.frame_done   = frame_end;
		res_nx.rejected     = rej;
		res_nx.sequence_now = seq_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			crc_q       <= CRC_INIT;
			seq_q       <= '0;
			left_q      <= '0;
			inside_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (fire) begin
				step_q <= is_last ? '0 : step_q + STEP_W'(1);
				if (feed) begin
					crc_q <= crc_feed(crc_base, byte_nx);
				end
			end
			if (item_done && !rej) begin
				if (!inside_q) begin
					inside_q <= 1'b1;
					left_q   <= item_s1.frame_len - 8'd1;
				end else if (left_q > 8'd1) begin
					left_q <= left_q - 8'd1;
				end else begin
					left_q   <= '0;
					inside_q <= 1'b0;
				end
			end
			if (cfg.seq_clr) begin
				seq_q <= '0;
			end else if (fire && frame_end) begin
				seq_q <= seq_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_nx;
		end
	end

endmodule
